@@ sv/smv_pkg.sv @@
// Shared types and constants for the sparse matrix-vector multiply core.
// No dependencies; every other file imports this package.
`default_nettype none

package smv_pkg;

    localparam int ACT_W     = 2;
    localparam int IDX_W     = 10;
    localparam int DATA_W    = 32;
    localparam int ACC_W     = 64;
    localparam int ROW_W     = 10;
    localparam int RC_W      = 11;
    localparam int REG_IDX_W = 2;
    localparam int TERMB_W   = ACC_W - 16;

    // action codes of an input word
    localparam logic [ACT_W-1:0] ACT_LOAD  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_ENTRY = 2'd1;
    localparam logic [ACT_W-1:0] ACT_CLOSE = 2'd2;

    // configuration register indexes
    localparam logic [REG_IDX_W-1:0] REG_ALPHA = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_BETA  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_ROWS  = 2'd2;

    localparam logic [DATA_W-1:0] ALPHA_RESET = 32'h0001_0000;
    localparam logic [DATA_W-1:0] BETA_RESET  = 32'h0000_0000;
    localparam logic [RC_W-1:0]   MAX_ROWS    = 11'd1024;

    localparam logic [ACC_W-1:0]  ACC_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [ACC_W-1:0]  ACC_MIN = 64'h8000_0000_0000_0000;
    localparam logic [DATA_W-1:0] Z_MAX   = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] Z_MIN   = 32'h8000_0000;

    // close-row partial terms handed from the accumulator to the finish stage
    typedef struct packed {
        logic signed [ACC_W-1:0]   ph;      // alpha * acc[63:32]
        logic signed [DATA_W-1:0]  pl_sh;   // floor(alpha * acc[31:0] / 2^32)
        logic signed [TERMB_W-1:0] term_b;  // floor(beta * y / 2^16)
        logic                      ovf;
    } fin_t;

    typedef struct packed {
        logic [ROW_W-1:0]  row_index;
        logic [DATA_W-1:0] z_value;
        logic              overflow;
        logic              last_row;
    } res_t;

endpackage

`default_nettype wire

@@ sv/smv_ifs.sv @@
// Valid/ready channel interfaces: input words, result words, config writes.
// Depends on smv_pkg for field widths.
`default_nettype none

interface smv_in_if;
    import smv_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [ACT_W-1:0]         action;
    logic [IDX_W-1:0]         index;
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] y_value;

    modport source (output valid, action, index, value, y_value, input ready);
    modport sink   (input valid, action, index, value, y_value, output ready);
endinterface

interface smv_out_if;
    import smv_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [ROW_W-1:0]         row_index;
    logic signed [DATA_W-1:0] z_value;
    logic                     overflow;
    logic                     last_row;

    modport source (output valid, row_index, z_value, overflow, last_row, input ready);
    modport sink   (input valid, row_index, z_value, overflow, last_row, output ready);
endinterface

interface smv_cfg_if;
    import smv_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [REG_IDX_W-1:0] index;
    logic [DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ sv/sparse_matrix_vector_multiply_core.sv @@
// Top level of the CSR sparse matrix-vector multiply core, z = alpha*A*x + beta*y.
// Depends on smv_pkg, smv_ifs, smv_xstore, smv_accum and smv_finish.
//
//  channel  | dir | word                                  | accepted when
//  ---------+-----+---------------------------------------+---------------------
//  item     | in  | action, index, value, y_value         | item.valid & ready
//  result   | out | row_index, z_value, overflow, last_row | result.valid & ready
//  cfg      | in  | index, data                           | cfg.valid & ready
//
// One input word per cycle while no stage is held. A close word's result is registered
// in turn through the x read, the shared 32x32 multiply, the accumulate / alpha products
// and the sum before it is valid.
// Only the result register back-pressures; when it is full and not taken,
// words still flow into empty stages until the pipe is full.
// Reset (rst_n low, asynchronous) clears the accumulator, row counter and
// config registers; the x store is not cleared and needs no clearing pass.
`default_nettype none

module sparse_matrix_vector_multiply_core #(
    parameter int VECTOR_DEPTH = 1024
) (
    input  logic       clk,
    input  logic       rst_n,
    smv_in_if.sink     item,
    smv_out_if.source  result,
    smv_cfg_if.sink    cfg
);
    import smv_pkg::*;

    localparam int AW = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;
    // one spare bit so the depth itself fits in the range compare
    localparam int EW = ((AW > IDX_W) ? AW : IDX_W) + 1;

    // configuration
    logic signed [DATA_W-1:0] alpha_reg;
    logic signed [DATA_W-1:0] beta_reg;
    logic [RC_W-1:0]          rows_reg;

    // pipeline control
    logic v1_reg, v2_reg, v3_reg, out_valid_reg;
    logic v1_next, v2_next, v3_next, out_valid_next;
    logic close3_reg;
    logic out_free, mv1, mv2, mv3, accept;

    // stage 1: words waiting for the multiplier
    logic [ACT_W-1:0]         act1_reg;
    logic signed [DATA_W-1:0] val1_reg;
    logic signed [DATA_W-1:0] y1_reg;
    logic                     ok1_reg;
    logic [DATA_W-1:0]        x_data;

    // stage 2: products waiting for the accumulator
    logic [ACT_W-1:0]         act2_reg;
    logic signed [ACC_W-1:0]  prod2_reg;

    logic [EW-1:0]            idx_ext;
    logic [AW-1:0]            addr;
    logic                     in_range;
    logic signed [DATA_W-1:0] mul_a;
    logic signed [DATA_W-1:0] mul_b;
    logic signed [ACC_W-1:0]  mul_p;
    fin_t                     fin;
    res_t                     res;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg <= ALPHA_RESET;
            beta_reg  <= BETA_RESET;
            rows_reg  <= MAX_ROWS;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_ALPHA: alpha_reg <= cfg.data;
                REG_BETA:  beta_reg  <= cfg.data;
                REG_ROWS:  rows_reg  <= cfg.data[RC_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // a stage advances when the one after it is empty or advancing
    assign out_free   = !out_valid_reg || result.ready;
    assign mv3        = v3_reg && (!close3_reg || out_free);
    assign mv2        = v2_reg && (!v3_reg || mv3);
    assign mv1        = v1_reg && (!v2_reg || mv2);
    assign item.ready = !v1_reg || mv1;
    assign accept     = item.valid && item.ready;

    always_comb
    begin
        v1_next        = accept ? 1'b1 : (mv1 ? 1'b0 : v1_reg);
        v2_next        = mv1 ? 1'b1 : (mv2 ? 1'b0 : v2_reg);
        v3_next        = mv2 ? 1'b1 : (mv3 ? 1'b0 : v3_reg);
        out_valid_next = (mv3 && close3_reg) ? 1'b1 :
                         (result.ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            v1_reg        <= v1_next;
            v2_reg        <= v2_next;
            v3_reg        <= v3_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // columns and load indexes beyond the store are dropped
    assign idx_ext  = EW'(item.index);
    assign addr     = idx_ext[AW-1:0];
    assign in_range = (idx_ext < EW'(VECTOR_DEPTH));

    smv_xstore #(
        .DEPTH (VECTOR_DEPTH),
        .AW    (AW)
    ) u_xstore (
        .clk     (clk),
        .wr_en   (accept && item.action == ACT_LOAD && in_range),
        .wr_addr (addr),
        .wr_data (item.value),
        .rd_en   (accept && item.action == ACT_ENTRY),
        .rd_addr (addr),
        .rd_data (x_data)
    );

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act1_reg <= item.action;
            val1_reg <= item.value;
            y1_reg   <= item.y_value;
            ok1_reg  <= in_range;
        end
    end

    // one multiplier: value * x for entries, beta * y for closes
    always_comb
    begin
        if (act1_reg == ACT_CLOSE)
        begin
            mul_a = beta_reg;
            mul_b = y1_reg;
        end
        else
        begin
            mul_a = val1_reg;
            mul_b = ok1_reg ? $signed(x_data) : '0;
        end
    end

    assign mul_p = mul_a * mul_b;

    always_ff @(posedge clk)
    begin
        if (mv1)
        begin
            act2_reg  <= act1_reg;
            prod2_reg <= mul_p;
        end
        if (mv2)
        begin
            close3_reg <= (act2_reg == ACT_CLOSE);
        end
    end

    smv_accum u_accum (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (mv2),
        .act   (act2_reg),
        .prod  (prod2_reg),
        .alpha (alpha_reg),
        .fin   (fin)
    );

    smv_finish u_finish (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (mv3 && close3_reg),
        .fin   (fin),
        .rows  (rows_reg),
        .res   (res)
    );

    assign result.valid     = out_valid_reg;
    assign result.row_index = res.row_index;
    assign result.z_value   = res.z_value;
    assign result.overflow  = res.overflow;
    assign result.last_row  = res.last_row;

endmodule

`default_nettype wire

@@ sv/smv_xstore.sv @@
// Storage for the x vector: one write port, one registered read port.
// Depends on smv_pkg for the data width.
`default_nettype none

module smv_xstore #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                      clk,
    input  logic                      wr_en,
    input  logic [AW-1:0]             wr_addr,
    input  logic [smv_pkg::DATA_W-1:0] wr_data,
    input  logic                      rd_en,
    input  logic [AW-1:0]             rd_addr,
    output logic [smv_pkg::DATA_W-1:0] rd_data
);
    import smv_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ sv/smv_accum.sv @@
// Row accumulator with 64-bit saturation, plus the alpha partial products
// and beta term formed when a row closes. Depends on smv_pkg.
`default_nettype none

module smv_accum (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             adv,
    input  logic [smv_pkg::ACT_W-1:0]        act,
    input  logic signed [smv_pkg::ACC_W-1:0] prod,
    input  logic signed [smv_pkg::DATA_W-1:0] alpha,
    output smv_pkg::fin_t                    fin
);
    import smv_pkg::*;

    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic                     ovf_seen_reg;
    logic                     ovf_seen_next;
    logic [ACC_W:0]           sum_ext;
    logic                     pos_sat;
    logic                     neg_sat;
    logic signed [DATA_W-1:0] acc_hi;
    logic signed [ACC_W-1:0]  ph;
    logic signed [ACC_W-1:0]  pl;
    fin_t                     fin_reg;

    assign sum_ext = {acc_reg[ACC_W-1], acc_reg} + {prod[ACC_W-1], prod};
    assign pos_sat = !sum_ext[ACC_W] && sum_ext[ACC_W-1];
    assign neg_sat = sum_ext[ACC_W] && !sum_ext[ACC_W-1];

    // split alpha * acc into two 32-bit products; the low half is unsigned
    assign acc_hi = acc_reg[ACC_W-1:DATA_W];
    assign ph     = alpha * acc_hi;
    assign pl     = alpha * $signed({1'b0, acc_reg[DATA_W-1:0]});

    always_comb
    begin
        acc_next      = acc_reg;
        ovf_seen_next = ovf_seen_reg;
        if (adv)
        begin
            case (act)
                ACT_ENTRY:
                begin
                    if (pos_sat)
                    begin
                        acc_next      = ACC_MAX;
                        ovf_seen_next = 1'b1;
                    end
                    else if (neg_sat)
                    begin
                        acc_next      = ACC_MIN;
                        ovf_seen_next = 1'b1;
                    end
                    else
                    begin
                        acc_next = sum_ext[ACC_W-1:0];
                    end
                end
                ACT_CLOSE:
                begin
                    acc_next      = '0;
                    ovf_seen_next = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg      <= '0;
            ovf_seen_reg <= 1'b0;
        end
        else
        begin
            acc_reg      <= acc_next;
            ovf_seen_reg <= ovf_seen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && act == ACT_CLOSE)
        begin
            fin_reg.ph     <= ph;
            fin_reg.pl_sh  <= pl[ACC_W-1:DATA_W];
            fin_reg.term_b <= prod[ACC_W-1:16];
            fin_reg.ovf    <= ovf_seen_reg;
        end
    end

    assign fin = fin_reg;

endmodule

`default_nettype wire

@@ sv/smv_finish.sv @@
// Final sum and 32-bit saturation of a closed row, row counter with wrap,
// and the result payload register. Depends on smv_pkg.
`default_nettype none

module smv_finish (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     adv,
    input  smv_pkg::fin_t            fin,
    input  logic [smv_pkg::RC_W-1:0] rows,
    output smv_pkg::res_t            res
);
    import smv_pkg::*;

    logic signed [ACC_W:0] sum;
    logic                  pos_sat;
    logic                  neg_sat;
    logic [DATA_W-1:0]     z;
    logic [RC_W-1:0]       eff_rows;
    logic                  last;
    logic [ROW_W-1:0]      row_reg;
    logic [ROW_W-1:0]      row_next;
    res_t                  res_reg;

    assign sum = (ACC_W + 1)'(fin.ph) + (ACC_W + 1)'(fin.pl_sh) + (ACC_W + 1)'(fin.term_b);

    // saturate when bit 31 and the bits above it are not all copies of the sign
    assign pos_sat = !sum[ACC_W] && (|sum[ACC_W:DATA_W-1]);
    assign neg_sat = sum[ACC_W] && !(&sum[ACC_W:DATA_W-1]);

    always_comb
    begin
        if (pos_sat)
        begin
            z = Z_MAX;
        end
        else if (neg_sat)
        begin
            z = Z_MIN;
        end
        else
        begin
            z = sum[DATA_W-1:0];
        end
    end

    // zero or an oversized row count acts as the full 1024 rows
    assign eff_rows = (rows == '0 || rows > MAX_ROWS) ? MAX_ROWS : rows;
    assign last     = ({1'b0, row_reg} == (eff_rows - RC_W'(1)));
    assign row_next = adv ? (last ? '0 : row_reg + ROW_W'(1)) : row_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
        end
        else
        begin
            row_reg <= row_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_reg.row_index <= row_reg;
            res_reg.z_value   <= z;
            res_reg.overflow  <= fin.ovf || pos_sat || neg_sat;
            res_reg.last_row  <= last;
        end
    end

    assign res = res_reg;

endmodule

`default_nettype wire

@@ sv/smv_checker.sv @@
// Port-level checks for the sparse matrix-vector multiply core, bound to the top.
// Depends on smv_pkg for widths and the close action code.
`default_nettype none

module smv_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         item_valid,
    input logic                         item_ready,
    input logic [smv_pkg::ACT_W-1:0]    item_action,
    input logic                         result_valid,
    input logic                         result_ready,
    input logic [smv_pkg::ROW_W-1:0]    result_row_index,
    input logic [smv_pkg::DATA_W-1:0]   result_z_value,
    input logic                         result_last_row
);
    import smv_pkg::*;

    logic [ROW_W-1:0] exp_row_reg;
    logic [2:0]       pending_reg;
    logic             close_in;
    logic             res_out;

    assign close_in = item_valid && item_ready && item_action == ACT_CLOSE;
    assign res_out  = result_valid && result_ready;

    // track the row the next result must carry and closes not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_row_reg <= '0;
            pending_reg <= '0;
        end
        else
        begin
            if (res_out)
            begin
                exp_row_reg <= result_last_row ? '0 : result_row_index + ROW_W'(1);
            end
            pending_reg <= pending_reg + {2'b00, close_in} - {2'b00, res_out};
        end
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(result_row_index) && $stable(result_z_value))
        else $error("result word changed while stalled");

    a_row_seq: assert property (@(posedge clk) disable iff (!rst_n)
        res_out |-> result_row_index == exp_row_reg)
        else $error("row index out of sequence");

    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> pending_reg != '0)
        else $error("result without a pending close word");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !item_ready |-> result_valid && !result_ready)
        else $error("input stalled while the result side is free");

endmodule

bind sparse_matrix_vector_multiply_core smv_checker u_smv_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .item_valid       (item.valid),
    .item_ready       (item.ready),
    .item_action      (item.action),
    .result_valid     (result.valid),
    .result_ready     (result.ready),
    .result_row_index (result.row_index),
    .result_z_value   (result.z_value),
    .result_last_row  (result.last_row)
);

`default_nettype wire
